>>> hw/rtl/cuk_pkg.sv
// Shared constants and types for the CSI-u key event parser.
package cuk_pkg;

	localparam int unsigned MAX_DIGITS_DEF = 7;

	localparam int unsigned ACC_W  = 24;
	localparam int unsigned MOD_W  = 8;
	localparam int unsigned EVT_W  = 2;
	localparam int unsigned CTRL_W = 5;
	localparam int unsigned BYTE_W = 8;

	// packed result beat: tdata holds code, event, modifiers, control byte, zero pad
	localparam int unsigned RES_DATA_BITS = ACC_W + EVT_W + MOD_W + CTRL_W;
	localparam int unsigned RES_TDATA_W   = ((RES_DATA_BITS + 7) / 8) * 8;
	localparam int unsigned RES_TUSER_W   = 2;

	localparam logic [BYTE_W-1:0] CH_U         = 8'h75;
	localparam logic [BYTE_W-1:0] CH_COLON     = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_SEMI      = 8'h3B;
	localparam logic [BYTE_W-1:0] CH_ZERO      = 8'h30;
	localparam logic [BYTE_W-1:0] CH_NINE      = 8'h39;
	localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_UPPER_A   = 8'h41;
	localparam logic [BYTE_W-1:0] CH_UPPER_Z   = 8'h5A;
	localparam logic [BYTE_W-1:0] CH_LOWER_A   = 8'h61;
	localparam logic [BYTE_W-1:0] CH_LOWER_Z   = 8'h7A;

	localparam logic [ACC_W-1:0]  ASCII_MAX    = 24'h00007F;
	localparam logic [CTRL_W-1:0] CTRL_FS      = 5'h1C;
	localparam int unsigned       MOD_CTRL_BIT = 2;

	typedef enum logic [1:0] {
		SEC_KEY    = 2'd0,
		SEC_MODS   = 2'd1,
		SEC_IGNORE = 2'd2
	} section_t;

	typedef struct packed {
		logic              parse_ok;
		logic [ACC_W-1:0]  key_code;
		logic [EVT_W-1:0]  event_kind;
		logic [MOD_W-1:0]  modifier_bits;
		logic              ctrl_ok;
		logic [CTRL_W-1:0] ctrl_byte;
	} result_t;

endpackage

>>> hw/rtl/csi_u_key_event_parser.sv
// CSI-u key event parser: one body byte per cycle in unless stalled, one decoded key event per body out.
// Feed the body of a CSI-u key escape (the bytes after "ESC [") one byte per beat on the
// slave stream, with tlast on the final byte; a trailing 'u' on that byte is dropped.
// Unless stalled, it takes one byte every cycle, whatever the body length: each byte passes an
// input register and then one pass of parser logic (a times-ten add into the digit
// accumulator plus the subfield close checks) that updates the small state registers.
// On the tlast byte that same pass closes the open subfield, forms the Ctrl mapping and
// loads the result register, which offers the result beat once the last byte has left
// the input register. The result register parts the two sides: bytes keep flowing
// while a result waits, and tready drops only while the input register holds the next
// body's last byte and the waiting result beat has not been taken.
// tuser bit 0 is parse_ok and bit 1 is ctrl_ok; on a format error every field is zero.
// Key code and event subfields take 1 to MAX_DIGITS decimal digits.
module csi_u_key_event_parser
	import cuk_pkg::*;
#(
	parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [BYTE_W-1:0]      s_axis_tdata,  // [7:0] in_byte
	input  logic                   s_axis_tlast,  // is_last
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [23:0] key_code, [25:24] event_kind, [33:26] modifier_bits, [38:34] ctrl_byte,
	// [39] zero pad
	output logic [RES_TDATA_W-1:0] m_axis_tdata,
	output logic [RES_TUSER_W-1:0] m_axis_tuser   // [0] parse_ok, [1] ctrl_ok
);

	// digit count saturates at MAX_DIGITS + 1
	localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 2);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

	// input register stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// parser state
	section_t          sec_q;
	logic              sub_q;
	logic [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ACC_W-1:0]  code_q;
	logic [MOD_W-1:0]  mods_q;
	logic [EVT_W-1:0]  evt_q;
	logic              err_q;

	// result register
	logic              out_valid_q;
	result_t           out_q;

	logic              advance;
	section_t          sec_n;
	logic              sub_n;
	logic [ACC_W-1:0]  acc_n;
	logic [CNT_W-1:0]  cnt_n;
	logic [ACC_W-1:0]  code_n;
	logic [MOD_W-1:0]  mods_n;
	logic [EVT_W-1:0]  evt_n;
	logic              err_n;
	result_t           res;

	// move the staged byte on; only a last byte needs room in the result register
	assign advance       = valid_s1 && (!last_s1 || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// one pass of the parser: apply the byte, then on the last byte close the open subfield
	always_comb begin : parse
		logic             is_digit;
		logic [ACC_W-1:0] digit_val;
		logic             cnt_ok;
		logic             code_is_letter;

		sec_n  = sec_q;
		sub_n  = sub_q;
		acc_n  = acc_q;
		cnt_n  = cnt_q;
		code_n = code_q;
		mods_n = mods_q;
		evt_n  = evt_q;
		err_n  = err_q;

		is_digit  = byte_s1 inside {[CH_ZERO:CH_NINE]};
		digit_val = ACC_W'(byte_s1 - CH_ZERO);
		cnt_ok    = (cnt_q != '0) && (cnt_q <= MAX_CNT);

		// drop a trailing 'u' on the last byte
		if (!(last_s1 && byte_s1 == CH_U)) begin
			case (sec_q)
				SEC_KEY: begin
					if (!sub_q) begin
						if (is_digit) begin
							acc_n = (acc_q << 3) + (acc_q << 1) + digit_val;
							if (cnt_q <= MAX_CNT) cnt_n = cnt_q + 1'b1;
						end else if (byte_s1 == CH_COLON || byte_s1 == CH_SEMI) begin
							if (!cnt_ok) err_n = 1'b1;
							else code_n = acc_q;
							acc_n = '0;
							cnt_n = '0;
							if (byte_s1 == CH_COLON) begin
								sub_n = 1'b1;
							end else begin
								sec_n = SEC_MODS;
								sub_n = 1'b0;
							end
						end else begin
							err_n = 1'b1;
						end
					end else if (byte_s1 == CH_SEMI) begin
						// later key subfields are skipped
						sec_n = SEC_MODS;
						sub_n = 1'b0;
						acc_n = '0;
						cnt_n = '0;
					end
				end
				SEC_MODS: begin
					if (is_digit) begin
						acc_n = (acc_q << 3) + (acc_q << 1) + digit_val;
						if (cnt_q <= MAX_CNT) cnt_n = cnt_q + 1'b1;
					end else if (!sub_q && (byte_s1 == CH_COLON || byte_s1 == CH_SEMI)) begin
						if (cnt_q != '0) begin
							if (!cnt_ok) err_n = 1'b1;
							else if (acc_q != '0) mods_n = MOD_W'(acc_q - 1'b1);
						end
						acc_n = '0;
						cnt_n = '0;
						if (byte_s1 == CH_COLON) sub_n = 1'b1;
						else sec_n = SEC_IGNORE;
					end else if (sub_q && byte_s1 == CH_SEMI) begin
						if (!cnt_ok || acc_q == '0 || acc_q > ACC_W'(3)) err_n = 1'b1;
						else evt_n = EVT_W'(acc_q - 1'b1);
						acc_n = '0;
						cnt_n = '0;
						sec_n = SEC_IGNORE;
					end else begin
						err_n = 1'b1;
					end
				end
				default: begin
					// everything after the second ';' is ignored
				end
			endcase
		end

		// close whatever subfield is still open at the end of the body
		cnt_ok = (cnt_n != '0) && (cnt_n <= MAX_CNT);
		if (last_s1) begin
			if (sec_n == SEC_KEY && !sub_n) begin
				if (!cnt_ok) err_n = 1'b1;
				else code_n = acc_n;
			end else if (sec_n == SEC_MODS && !sub_n) begin
				if (cnt_n != '0) begin
					if (!cnt_ok) err_n = 1'b1;
					else if (acc_n != '0) mods_n = MOD_W'(acc_n - 1'b1);
				end
			end else if (sec_n == SEC_MODS && sub_n) begin
				if (!cnt_ok || acc_n == '0 || acc_n > ACC_W'(3)) err_n = 1'b1;
				else evt_n = EVT_W'(acc_n - 1'b1);
			end
		end

		// Ctrl chord mapping for ASCII codes
		code_is_letter = code_n[6:0] inside {[CH_UPPER_A[6:0]:CH_UPPER_Z[6:0]],
			[CH_LOWER_A[6:0]:CH_LOWER_Z[6:0]]};
		res               = '0;
		res.parse_ok      = 1'b1;
		res.key_code      = code_n;
		res.event_kind    = evt_n;
		res.modifier_bits = mods_n;
		if (mods_n[MOD_CTRL_BIT] && code_n <= ASCII_MAX) begin
			if (code_is_letter) begin
				res.ctrl_ok   = 1'b1;
				res.ctrl_byte = code_n[CTRL_W-1:0];
			end else if (code_n == ACC_W'(CH_SPACE)) begin
				res.ctrl_ok   = 1'b1;
				res.ctrl_byte = '0;
			end else if (code_n == ACC_W'(CH_BACKSLASH)) begin
				res.ctrl_ok   = 1'b1;
				res.ctrl_byte = CTRL_FS;
			end
		end
		if (err_n) res = '0;
	end

	// advance parser state; the last byte returns it to the start of a new body
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= SEC_KEY;
			sub_q  <= 1'b0;
			acc_q  <= '0;
			cnt_q  <= '0;
			code_q <= '0;
			mods_q <= '0;
			evt_q  <= '0;
			err_q  <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				sec_q  <= SEC_KEY;
				sub_q  <= 1'b0;
				acc_q  <= '0;
				cnt_q  <= '0;
				code_q <= '0;
				mods_q <= '0;
				evt_q  <= '0;
				err_q  <= 1'b0;
			end else begin
				sec_q  <= sec_n;
				sub_q  <= sub_n;
				acc_q  <= acc_n;
				cnt_q  <= cnt_n;
				code_q <= code_n;
				mods_q <= mods_n;
				evt_q  <= evt_n;
				err_q  <= err_n;
			end
		end
	end

	// result register: load on the last byte, hold until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(RES_TDATA_W - RES_DATA_BITS){1'b0}}, out_q.ctrl_byte,
		out_q.modifier_bits, out_q.event_kind, out_q.key_code};
	assign m_axis_tuser  = {out_q.ctrl_ok, out_q.parse_ok};

endmodule

>>> tb/key_event_tracker_pkg.sv
// Key event tracker: predicts decoded key events from body bytes and checks result beats.
package key_event_tracker_pkg;

	import cuk_pkg::*;

	localparam int unsigned EVT_LO  = ACC_W;
	localparam int unsigned MOD_LO  = EVT_LO + EVT_W;
	localparam int unsigned CTRL_LO = MOD_LO + MOD_W;
	localparam int unsigned PAD_LO  = CTRL_LO + CTRL_W;

	class key_event_tracker;
		section_t          section;
		bit                later_subfield;
		logic [ACC_W-1:0]  digit_value;
		int unsigned       digit_total;
		logic [ACC_W-1:0]  key_value;
		logic [MOD_W-1:0]  mod_mask;
		logic [EVT_W-1:0]  evt_value;
		bit                body_bad;
		result_t           pending_events[$];
		int unsigned       fails;

		function new();
			fails = 0;
			start_body();
		endfunction

		function void start_body();
			section        = SEC_KEY;
			later_subfield = 1'b0;
			digit_value    = '0;
			digit_total    = 0;
			key_value      = '0;
			mod_mask       = '0;
			evt_value      = '0;
			body_bad       = 1'b0;
		endfunction

		function int unsigned pending();
			return pending_events.size();
		endfunction

		function void drop_digits();
			digit_value = '0;
			digit_total = 0;
		endfunction

		function bit digits_fit();
			return digit_total >= 1 && digit_total <= MAX_DIGITS_DEF;
		endfunction

		// accumulate modulo 2^24; count saturates one past the limit
		function void add_digit(logic [BYTE_W-1:0] c);
			logic [31:0] wide;
			wide        = digit_value * 10 + (c - CH_ZERO);
			digit_value = wide[ACC_W-1:0];
			if (digit_total <= MAX_DIGITS_DEF) digit_total++;
		endfunction

		function void close_key();
			if (!digits_fit()) body_bad = 1'b1;
			else key_value = digit_value;
			drop_digits();
		endfunction

		function void close_mods();
			logic [ACC_W-1:0] less_one;
			if (digit_total != 0) begin
				less_one = digit_value - 1'b1;
				if (!digits_fit()) body_bad = 1'b1;
				else if (digit_value != 0) mod_mask = less_one[MOD_W-1:0];
			end
			drop_digits();
		endfunction

		function void close_event();
			logic [ACC_W-1:0] less_one;
			less_one = digit_value - 1'b1;
			if (!digits_fit() || digit_value < 1 || digit_value > 3) body_bad = 1'b1;
			else evt_value = less_one[EVT_W-1:0];
			drop_digits();
		endfunction

		function void take_byte(logic [BYTE_W-1:0] c);
			bit is_digit;
			is_digit = c >= CH_ZERO && c <= CH_NINE;
			case (section)
				SEC_KEY: begin
					if (!later_subfield) begin
						if (is_digit) begin
							add_digit(c);
						end else if (c == CH_COLON) begin
							close_key();
							later_subfield = 1'b1;
						end else if (c == CH_SEMI) begin
							close_key();
							section        = SEC_MODS;
							later_subfield = 1'b0;
						end else begin
							body_bad = 1'b1;
						end
					end else if (c == CH_SEMI) begin
						// later key subfields are skipped up to the section break
						section        = SEC_MODS;
						later_subfield = 1'b0;
						drop_digits();
					end
				end
				SEC_MODS: begin
					if (is_digit) begin
						add_digit(c);
					end else if (!later_subfield && c == CH_COLON) begin
						close_mods();
						later_subfield = 1'b1;
					end else if (c == CH_SEMI) begin
						if (later_subfield) close_event();
						else close_mods();
						section = SEC_IGNORE;
					end else begin
						body_bad = 1'b1;
					end
				end
				default: ;
			endcase
		endfunction

		// note one accepted body byte; the last byte yields one expected event
		function void note_body_byte(logic [BYTE_W-1:0] c, bit last);
			result_t ev;
			if (!(last && c == CH_U)) take_byte(c);
			if (!last) return;
			if (section == SEC_KEY && !later_subfield) close_key();
			else if (section == SEC_MODS && !later_subfield) close_mods();
			else if (section == SEC_MODS) close_event();
			ev = '0;
			if (!body_bad) begin
				ev.parse_ok      = 1'b1;
				ev.key_code      = key_value;
				ev.event_kind    = evt_value;
				ev.modifier_bits = mod_mask;
				if (mod_mask[MOD_CTRL_BIT] && key_value <= ASCII_MAX) begin
					if ((key_value >= CH_UPPER_A && key_value <= CH_UPPER_Z) ||
					    (key_value >= CH_LOWER_A && key_value <= CH_LOWER_Z)) begin
						// clearing the case bit and masking to five bits keeps the low five
						ev.ctrl_ok   = 1'b1;
						ev.ctrl_byte = key_value[CTRL_W-1:0];
					end else if (key_value == CH_SPACE) begin
						ev.ctrl_ok   = 1'b1;
						ev.ctrl_byte = '0;
					end else if (key_value == CH_BACKSLASH) begin
						ev.ctrl_ok   = 1'b1;
						ev.ctrl_byte = CTRL_FS;
					end
				end
			end
			pending_events.push_back(ev);
			start_body();
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got, time now);
			if (want !== got) begin
				$display("%0t ns: %s mismatch, expected %0h, actual %0h", now, name, want, got);
				fails++;
			end
		endfunction

		function void check_key_event(time now, logic [RES_TDATA_W-1:0] d,
		                              logic [RES_TUSER_W-1:0] u);
			result_t ev;
			if (pending_events.size() == 0) begin
				$display("%0t ns: unexpected result beat, expected none, actual tdata %h tuser %b",
				         now, d, u);
				fails++;
				return;
			end
			ev = pending_events.pop_front();
			compare_field("parse_ok", ev.parse_ok, u[0], now);
			compare_field("ctrl_ok", ev.ctrl_ok, u[1], now);
			compare_field("key_code", ev.key_code, d[0 +: ACC_W], now);
			compare_field("event_kind", ev.event_kind, d[EVT_LO +: EVT_W], now);
			compare_field("modifier_bits", ev.modifier_bits, d[MOD_LO +: MOD_W], now);
			compare_field("ctrl_byte", ev.ctrl_byte, d[CTRL_LO +: CTRL_W], now);
			compare_field("tdata pad", 0, d[RES_TDATA_W-1:PAD_LO], now);
		endfunction
	endclass

endpackage

>>> tb/tb.sv
// Testbench top for the CSI-u key event parser: random and directed bodies, checked per event.
module tb;
	import cuk_pkg::*;
	import key_event_tracker_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CLK_PERIOD  = 10;
	localparam int unsigned BYTE_TARGET = 1150;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned HOLD_CYCLES = 150;
	localparam int unsigned GAP_PCT     = 12;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [BYTE_W-1:0]      s_axis_tdata = '0;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [RES_TDATA_W-1:0] m_axis_tdata;
	logic [RES_TUSER_W-1:0] m_axis_tuser;

	key_event_tracker  tracker;
	logic [BYTE_W-1:0] body[$];      // body bytes waiting to go out
	int unsigned       bytes_sent = 0;
	bit                gaps_on = 1'b1;
	bit                hold_req = 1'b0;
	int unsigned       cycles = 0;

	csi_u_key_event_parser uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),   // [7:0] in_byte
		.s_axis_tlast  (s_axis_tlast),   // is_last
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),   // [23:0] key, [25:24] event, [33:26] mods, [38:34] ctrl
		.m_axis_tuser  (m_axis_tuser)    // [0] parse_ok, [1] ctrl_ok
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog: a hung handshake or a lost result ends here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("csi_u_key_event_parser test failed");
			$finish;
		end
	end

	// Sample both streams at the rising edge. Check the result beat first, then note the body
	// byte; a byte taken at this edge can never be the cause of the result seen at it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				tracker.check_key_event($time, m_axis_tdata, m_axis_tuser);
			if (s_axis_tvalid && s_axis_tready)
				tracker.note_body_byte(s_axis_tdata, s_axis_tlast);
		end
	end

	// Result side: stall at random, or hold off for a long count when asked, so that the
	// result register and the input register both fill and the block drops tready.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= !gaps_on || $urandom_range(99) >= GAP_PCT;
			end
		end
	end

	// Drive one byte beat. Call at a falling edge; returns at the falling edge after the
	// handshake with tvalid still high, so the caller either drives the next beat or drops
	// tvalid there, never both.
	task automatic push_beat(input logic [BYTE_W-1:0] b, input bit last);
		if (gaps_on && $urandom_range(99) < GAP_PCT) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_body();
		for (int i = 0; i < body.size(); i++)
			push_beat(body[i], i == body.size() - 1);
	endtask

	task automatic send_text(input string s);
		body.delete();
		for (int i = 0; i < s.len(); i++)
			body.push_back(s[i]);
		send_body();
	endtask

	// Append n in decimal, padded with leading zeros to at least width digits.
	function automatic void put_number(int unsigned n, int unsigned width);
		logic [BYTE_W-1:0] digs[$];
		int unsigned       v;
		v = n;
		do begin
			digs.push_front(8'(CH_ZERO + v % 10));
			v = v / 10;
		end while (v != 0);
		while (digs.size() < width)
			digs.push_front(CH_ZERO);
		foreach (digs[i])
			body.push_back(digs[i]);
	endfunction

	// Bias toward the bytes the parser reacts to, with any byte now and then.
	function automatic logic [BYTE_W-1:0] pick_char();
		case ($urandom_range(4))
			0: return 8'($urandom_range(CH_NINE, CH_ZERO));
			1: return CH_COLON;
			2: return CH_SEMI;
			3: return CH_U;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Build a well-formed body with random content; some picks are deliberately out of range
	// (too many digits, event outside 1..3) so the error paths see realistic bodies.
	function automatic void make_well_formed();
		int unsigned key;
		int unsigned width;
		int unsigned pick;
		body.delete();
		case ($urandom_range(5))
			0: key = $urandom_range(CH_UPPER_Z, CH_UPPER_A);
			1: key = $urandom_range(CH_LOWER_Z, CH_LOWER_A);
			2: key = $urandom_range(1) ? CH_SPACE : CH_BACKSLASH;
			3: key = $urandom_range(ASCII_MAX);
			4: key = $urandom_range(9999999);
			default: key = $urandom_range(999);
		endcase
		pick  = $urandom_range(19);
		width = (pick == 0) ? MAX_DIGITS_DEF + 1 : (pick < 3) ? $urandom_range(MAX_DIGITS_DEF, 1) : 0;
		put_number(key, width);
		// later key subfields: skipped by the parser
		if ($urandom_range(3) == 0) begin
			body.push_back(CH_COLON);
			repeat ($urandom_range(4)) body.push_back(pick_char());
		end
		if ($urandom_range(4) != 0) begin
			body.push_back(CH_SEMI);
			case ($urandom_range(5))
				0: ;
				1: put_number(0, 0);
				2: put_number($urandom_range(16, 1), 0);
				3: put_number($urandom_range(300), 0);
				4: put_number($urandom_range(9), MAX_DIGITS_DEF + 1);
				default: put_number($urandom_range(9, 1), $urandom_range(MAX_DIGITS_DEF, 1));
			endcase
			if ($urandom_range(2) == 0) begin
				body.push_back(CH_COLON);
				case ($urandom_range(7))
					0: ;
					1: put_number(0, 0);
					2: put_number($urandom_range(99, 4), 0);
					3: put_number($urandom_range(3, 1), $urandom_range(MAX_DIGITS_DEF + 1, 1));
					default: put_number($urandom_range(3, 1), 0);
				endcase
			end
			// trailing sections: ignored whatever they hold
			if ($urandom_range(4) == 0) begin
				body.push_back(CH_SEMI);
				repeat ($urandom_range(4)) body.push_back(8'($urandom_range(255)));
			end
		end
		if ($urandom_range(1)) body.push_back(CH_U);
	endfunction

	function automatic void make_body();
		int unsigned kind;
		kind = $urandom_range(9);
		if (kind < 8) begin
			make_well_formed();
		end else if (kind == 8) begin
			// corrupt one byte of a good body
			make_well_formed();
			body[$urandom_range(body.size() - 1)] = 8'($urandom_range(255));
		end else begin
			body.delete();
			repeat ($urandom_range(8, 1)) body.push_back(pick_char());
		end
	endfunction

	initial begin
		bit held;
		bit paused;
		held    = 1'b0;
		paused  = 1'b0;
		tracker = new();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed bodies: lone 'u' (empty key), Ctrl letter, backslash with the largest
		// modifier and a release, interior 'u', the lowest and highest byte values, and the
		// longest key code.
		send_text("u");
		send_text("97;5u");
		send_text("92;256:3u");
		send_text("1u2");
		body.delete();
		body.push_back(8'h00);
		body.push_back(8'hFF);
		send_body();
		send_text("9999999u");

		// Random bodies: one long receiver hold-off, a stretch with no idling on either side,
		// and one pause of the sender until every event is out.
		while (bytes_sent < BYTE_TARGET) begin
			if (!held && bytes_sent >= 300) begin
				held     = 1'b1;
				hold_req = 1'b1;
			end
			if (!paused && bytes_sent >= 800) begin
				paused = 1'b1;
				s_axis_tvalid <= 1'b0;
				while (tracker.pending() != 0) @(posedge clk);
				@(negedge clk);
			end
			gaps_on = !(bytes_sent >= 500 && bytes_sent < 700);
			make_body();
			send_body();
		end
		s_axis_tvalid <= 1'b0;
		gaps_on = 1'b1;

		// Drain, then watch the result side for any stray beat.
		while (tracker.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (tracker.fails == 0)
			$display("csi_u_key_event_parser test passed");
		else
			$display("csi_u_key_event_parser test failed");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/cuk_pkg.sv
hw/rtl/csi_u_key_event_parser.sv
tb/key_event_tracker_pkg.sv
tb/tb.sv
